@@ design/spi_eeprom_write_behind_controller_macros.svh @@
// Assertion helpers for the write-behind controller.
`ifndef SPI_EEPROM_WRITE_BEHIND_CONTROLLER_MACROS_SVH
`define SPI_EEPROM_WRITE_BEHIND_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEWB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sewb: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEWB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sewb: next-cycle check failed");

`endif

@@ design/sewb_pkg.sv @@
`default_nettype none

package sewb_pkg;

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_READ  = 2'd1;
    localparam logic [1:0] FN_DONE  = 2'd2;
    localparam logic [1:0] FN_LOAD  = 2'd3;

    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WRDI  = 8'h04;

    localparam int CACHE_DEPTH = 256;
    localparam int CACHE_AW    = 8;
    localparam int DATA_W      = 8;
    localparam int LOAD_CNT_W  = 9;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } st_t;

    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_WREN   = 11'b000_0000_0010,
        PH_WCMD   = 11'b000_0000_0100,
        PH_WADDR  = 11'b000_0000_1000,
        PH_WDATA  = 11'b000_0001_0000,
        PH_SCMD   = 11'b000_0010_0000,
        PH_SDUMMY = 11'b000_0100_0000,
        PH_WRDI   = 11'b000_1000_0000,
        PH_LCMD   = 11'b001_0000_0000,
        PH_LADDR  = 11'b010_0000_0000,
        PH_LDATA  = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic       cs_n;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] rd_data;
        logic       busy;
        logic       dropped;
        logic       load_done;
        logic       last;
    } res_t;

    function automatic res_t res_send(input logic [7:0] b);
        res_t r;
        r          = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = b;
        r.busy     = 1'b1;
        return r;
    endfunction

    function automatic res_t res_status(input logic cs_n, input logic busy,
                                        input logic [7:0] rd, input logic drop,
                                        input logic ld);
        res_t r;
        r           = '0;
        r.cs_n      = cs_n;
        r.rd_data   = rd;
        r.busy      = busy;
        r.dropped   = drop;
        r.load_done = ld;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/sewb_ram.sv @@
`default_nettype none

module sewb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/spi_eeprom_write_behind_controller.sv @@
// Write-behind controller for a 256-byte 25xx-style SPI EEPROM. The byte cache and the ring
// of pending write addresses sit in two synchronous memories; every event (host write, host
// read, end of an SPI byte transfer, start of a cache load) reads both memories when accepted in
// ST_IDLE; ST_EXEC modifies and writes them back and posts one or two result transfers. A new
// event is taken only once the previous write-back has been done, so no access can overlap
// another to the same entry. Results wait in a four-entry output queue, and the next event is
// accepted while up to two results are still waiting, so a slow consumer costs nothing until the
// queue holds three results. Neither memory is cleared after reset: cache bytes must be
// loaded or written before they are read.
`default_nettype none

`include "spi_eeprom_write_behind_controller_macros.svh"

module spi_eeprom_write_behind_controller #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] func,
    input  wire logic [7:0] addr,
    input  wire logic [7:0] wdata,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            cs_n,
    output logic            tx_valid,
    output logic [7:0]      tx_byte,
    output logic [7:0]      rd_data,
    output logic            busy_res,
    output logic            dropped,
    output logic            load_done,
    output logic            last
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    sewb_pkg::st_t    st_reg, st_next;
    sewb_pkg::phase_t phase_reg, phase_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [7:0]       cur_addr_reg, cur_addr_next;
    logic [sewb_pkg::LOAD_CNT_W-1:0] load_cnt_reg, load_cnt_next, load_cnt_inc;

    logic [1:0] func_reg;
    logic [7:0] addr_reg;
    logic [7:0] wdata_reg;
    logic [7:0] rx_reg;

    logic                          cache_we;
    logic [sewb_pkg::CACHE_AW-1:0] cache_waddr;
    logic [7:0]                    cache_wdata;
    logic [sewb_pkg::CACHE_AW-1:0] cache_raddr;
    logic [7:0]                    cache_rdata;

    logic             ring_we;
    logic [PTR_W-1:0] ring_waddr;
    logic [7:0]       ring_wdata;
    logic [PTR_W-1:0] ring_raddr;
    logic [7:0]       ring_rdata;
    logic [PTR_W-1:0] head_adv;

    sewb_pkg::res_t res0, res1, q_head;
    logic           push, push_two, pop, accept;

    sewb_pkg::res_t q_reg [sewb_pkg::OUTQ_DEPTH];
    logic [sewb_pkg::OUTQ_PTR_W-1:0] q_wr_reg, q_rd_reg;
    logic [sewb_pkg::OUTQ_CNT_W-1:0] q_cnt_reg;
    logic [sewb_pkg::OUTQ_CNT_W-1:0] push_cnt;

    assign in_ready = (st_reg == sewb_pkg::ST_IDLE)
                      && (q_cnt_reg <= sewb_pkg::OUTQ_CNT_W'(sewb_pkg::OUTQ_DEPTH - 2));
    assign accept   = in_valid && in_ready;

    assign cache_raddr = (func == sewb_pkg::FN_READ) ? addr : cur_addr_reg;
    assign ring_raddr  = ring_next(tail_reg);

    sewb_ram #(
        .WIDTH(sewb_pkg::DATA_W),
        .DEPTH(sewb_pkg::CACHE_DEPTH)
    ) u_cache (
        .clk  (clk),
        .we   (cache_we),
        .waddr(cache_waddr),
        .wdata(cache_wdata),
        .raddr(cache_raddr),
        .rdata(cache_rdata)
    );

    sewb_ram #(
        .WIDTH(sewb_pkg::DATA_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ring_we),
        .waddr(ring_waddr),
        .wdata(ring_wdata),
        .raddr(ring_raddr),
        .rdata(ring_rdata)
    );

    assign head_adv     = ring_next(head_reg);
    assign load_cnt_inc = load_cnt_reg + 1'b1;
    assign push         = (st_reg == sewb_pkg::ST_EXEC);

    always_comb
    begin
        st_next       = st_reg;
        phase_next    = phase_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cur_addr_next = cur_addr_reg;
        load_cnt_next = load_cnt_reg;
        cache_we      = 1'b0;
        cache_waddr   = addr_reg;
        cache_wdata   = wdata_reg;
        ring_we       = 1'b0;
        ring_waddr    = head_adv;
        ring_wdata    = addr_reg;
        res0          = sewb_pkg::res_status(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        res1          = sewb_pkg::res_send(sewb_pkg::OP_WREN);
        push_two      = 1'b0;

        if (st_reg == sewb_pkg::ST_IDLE)
        begin
            if (accept)
            begin
                st_next = sewb_pkg::ST_EXEC;
            end
        end
        else
        begin
            st_next = sewb_pkg::ST_IDLE;
            case (func_reg)
                sewb_pkg::FN_WRITE:
                begin
                    if (phase_reg == sewb_pkg::PH_IDLE)
                    begin
                        cache_we      = 1'b1;
                        cur_addr_next = addr_reg;
                        phase_next    = sewb_pkg::PH_WREN;
                        res0          = sewb_pkg::res_send(sewb_pkg::OP_WREN);
                    end
                    else if (head_adv == tail_reg)
                    begin
                        res0 = sewb_pkg::res_status(1'b0, 1'b1, 8'h00, 1'b1, 1'b0);
                    end
                    else
                    begin
                        ring_we   = 1'b1;
                        head_next = head_adv;
                        cache_we  = 1'b1;
                        res0      = sewb_pkg::res_status(1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
                    end
                end
                sewb_pkg::FN_READ:
                begin
                    res0 = sewb_pkg::res_status(phase_reg == sewb_pkg::PH_IDLE,
                                                phase_reg != sewb_pkg::PH_IDLE,
                                                cache_rdata, 1'b0, 1'b0);
                end
                sewb_pkg::FN_DONE:
                begin
                    case (phase_reg)
                        sewb_pkg::PH_WREN:
                        begin
                            res0       = sewb_pkg::res_status(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
                            res1       = sewb_pkg::res_send(sewb_pkg::OP_WRITE);
                            push_two   = 1'b1;
                            phase_next = sewb_pkg::PH_WCMD;
                        end
                        sewb_pkg::PH_WCMD:
                        begin
                            res0       = sewb_pkg::res_send(cur_addr_reg);
                            phase_next = sewb_pkg::PH_WADDR;
                        end
                        sewb_pkg::PH_WADDR:
                        begin
                            res0       = sewb_pkg::res_send(cache_rdata);
                            phase_next = sewb_pkg::PH_WDATA;
                        end
                        sewb_pkg::PH_WDATA:
                        begin
                            res0       = sewb_pkg::res_status(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
                            res1       = sewb_pkg::res_send(sewb_pkg::OP_RDSR);
                            push_two   = 1'b1;
                            phase_next = sewb_pkg::PH_SCMD;
                        end
                        sewb_pkg::PH_SCMD:
                        begin
                            res0       = sewb_pkg::res_send(8'h00);
                            phase_next = sewb_pkg::PH_SDUMMY;
                        end
                        sewb_pkg::PH_SDUMMY:
                        begin
                            res0     = sewb_pkg::res_status(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
                            push_two = 1'b1;
                            if (rx_reg[0])
                            begin
                                res1       = sewb_pkg::res_send(sewb_pkg::OP_RDSR);
                                phase_next = sewb_pkg::PH_SCMD;
                            end
                            else
                            begin
                                res1       = sewb_pkg::res_send(sewb_pkg::OP_WRDI);
                                phase_next = sewb_pkg::PH_WRDI;
                            end
                        end
                        sewb_pkg::PH_WRDI:
                        begin
                            phase_next = sewb_pkg::PH_IDLE;
                            if (head_reg != tail_reg)
                            begin
                                tail_next     = ring_raddr;
                                cur_addr_next = ring_rdata;
                                phase_next    = sewb_pkg::PH_WREN;
                                push_two      = 1'b1;
                            end
                        end
                        sewb_pkg::PH_LCMD:
                        begin
                            res0       = sewb_pkg::res_send(8'h00);
                            phase_next = sewb_pkg::PH_LADDR;
                        end
                        sewb_pkg::PH_LADDR:
                        begin
                            res0       = sewb_pkg::res_send(8'h00);
                            phase_next = sewb_pkg::PH_LDATA;
                        end
                        sewb_pkg::PH_LDATA:
                        begin
                            cache_we      = 1'b1;
                            cache_waddr   = load_cnt_reg[sewb_pkg::CACHE_AW-1:0];
                            cache_wdata   = rx_reg;
                            load_cnt_next = load_cnt_inc;
                            if (load_cnt_inc != sewb_pkg::LOAD_CNT_W'(sewb_pkg::CACHE_DEPTH))
                            begin
                                res0 = sewb_pkg::res_send(8'h00);
                            end
                            else
                            begin
                                res0 = sewb_pkg::res_status(1'b1, 1'b0, 8'h00, 1'b0, 1'b1);
                                phase_next = sewb_pkg::PH_IDLE;
                                if (head_reg != tail_reg)
                                begin
                                    tail_next     = ring_raddr;
                                    cur_addr_next = ring_rdata;
                                    phase_next    = sewb_pkg::PH_WREN;
                                    push_two      = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = sewb_pkg::PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    if (phase_reg == sewb_pkg::PH_IDLE)
                    begin
                        load_cnt_next = '0;
                        phase_next    = sewb_pkg::PH_LCMD;
                        res0          = sewb_pkg::res_send(sewb_pkg::OP_READ);
                    end
                    else
                    begin
                        res0 = sewb_pkg::res_status(1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
                    end
                end
            endcase
            res0.last = !push_two;
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= sewb_pkg::ST_IDLE;
            phase_reg    <= sewb_pkg::PH_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            cur_addr_reg <= '0;
            load_cnt_reg <= '0;
        end
        else
        begin
            st_reg       <= st_next;
            phase_reg    <= phase_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cur_addr_reg <= cur_addr_next;
            load_cnt_reg <= load_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            addr_reg  <= addr;
            wdata_reg <= wdata;
            rx_reg    <= rx_byte;
        end
    end

    // Output queue: one or two results go in per event, one transfer leaves per cycle while out_ready is high.
    assign pop      = out_valid && out_ready;
    assign push_cnt = push ? (push_two ? sewb_pkg::OUTQ_CNT_W'(2) : sewb_pkg::OUTQ_CNT_W'(1))
                           : '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[q_wr_reg] <= res0;
            if (push_two)
            begin
                q_reg[sewb_pkg::OUTQ_PTR_W'(q_wr_reg + 1'b1)] <= res1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_wr_reg  <= q_wr_reg + push_cnt[sewb_pkg::OUTQ_PTR_W-1:0];
            q_rd_reg  <= q_rd_reg + sewb_pkg::OUTQ_PTR_W'(pop);
            q_cnt_reg <= q_cnt_reg + push_cnt - sewb_pkg::OUTQ_CNT_W'(pop);
        end
    end

    assign q_head    = q_reg[q_rd_reg];
    assign out_valid = (q_cnt_reg != '0);
    assign cs_n      = q_head.cs_n;
    assign tx_valid  = q_head.tx_valid;
    assign tx_byte   = q_head.tx_byte;
    assign rd_data   = q_head.rd_data;
    assign busy_res  = q_head.busy;
    assign dropped   = q_head.dropped;
    assign load_done = q_head.load_done;
    assign last      = q_head.last;

    `SEWB_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, accept, st_reg == sewb_pkg::ST_EXEC)
    `SEWB_ASSERT_SAME(a_exec_has_room, clk, rst_n, st_reg == sewb_pkg::ST_EXEC,
                      q_cnt_reg <= sewb_pkg::OUTQ_CNT_W'(sewb_pkg::OUTQ_DEPTH - 2))
    `SEWB_ASSERT_SAME(a_load_count_range, clk, rst_n, phase_reg == sewb_pkg::PH_LDATA,
                      load_cnt_reg < sewb_pkg::LOAD_CNT_W'(sewb_pkg::CACHE_DEPTH))

endmodule

`default_nettype wire
